>>> rtl/clns_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; every other file refers to this package by scoped names.
package clns_pkg;

    typedef enum logic [2:0] {
        CMD_INIT  = 3'd0,
        CMD_CLEAR = 3'd1,
        CMD_GOTO  = 3'd2,
        CMD_PUT   = 3'd3,
        CMD_VOLTS = 3'd4,
        CMD_RAW   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        REG_ENABLE_PULSE = 2'd0,
        REG_NIBBLE_GAP   = 2'd1,
        REG_CLEAR_WAIT   = 2'd2,
        REG_POWER_WAIT   = 2'd3
    } t_reg_index;

    localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] LCD_CLS          = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
    localparam logic [7:0] ASCII_ZERO       = 8'h30;
    localparam logic [7:0] ASCII_POINT      = 8'h2E;

    localparam logic [7:0]  RESET_PULSE_US = 8'd20;
    localparam logic [7:0]  RESET_GAP_US   = 8'd20;
    localparam logic [17:0] RESET_CLEAR_US = 18'd2000;
    localparam logic [17:0] RESET_POWER_US = 18'd50000;
    localparam logic [17:0] US_PER_MS      = 18'd1000;

    // Timing settings as the back end uses them, milliseconds already scaled.
    typedef struct packed {
        logic [7:0]  pulse_us;
        logic [7:0]  gap_us;
        logic [17:0] clear_us;
        logic [17:0] power_us;
    } t_cfg;

    // One classified request: up to four bytes, all with the same RS level.
    typedef struct packed {
        logic            power_wait;
        logic            rs;
        logic [1:0]      last_byte;
        logic            clear_en;
        logic [1:0]      clear_byte;
        logic [3:0][7:0] bytes;
    } t_req;

    // One bus step as it leaves the block.
    typedef struct packed {
        logic        strobe;
        logic        rs;
        logic [3:0]  nibble;
        logic [7:0]  pulse_us;
        logic [17:0] wait_us;
        logic        last;
    } t_step;

endpackage

>>> rtl/clns_front.sv
// Front end: accepts requests, splits the voltage into digits and builds a request descriptor.
// Depends on clns_pkg.
module clns_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [2:0]          i_command,
    input  logic [7:0]          i_byte_value,
    input  logic                i_rs_select,
    input  logic [9:0]          i_volts,
    output logic                o_req_valid,
    output clns_pkg::t_req      o_req,
    input  logic                i_req_full
);

    logic             r_s1_valid;
    clns_pkg::t_cmd   r_s1_cmd;
    logic [7:0]       r_s1_byte;
    logic             r_s1_rs;
    logic [3:0]       r_s1_hund;
    logic [6:0]       r_s1_rem;

    logic             s1_advance;
    logic             cmd_known;
    logic [9:0]       volts_mod;
    logic [3:0]       n_hund;
    logic [6:0]       n_rem;
    logic [3:0]       tens;
    logic [3:0]       ones;

    assign s1_advance  = !r_s1_valid || !i_req_full;
    assign o_full      = !s1_advance;
    assign o_req_valid = r_s1_valid;

    always_comb begin
        unique case (clns_pkg::t_cmd'(i_command)) inside
            clns_pkg::CMD_INIT, clns_pkg::CMD_CLEAR, clns_pkg::CMD_GOTO,
            clns_pkg::CMD_PUT, clns_pkg::CMD_VOLTS, clns_pkg::CMD_RAW: cmd_known = 1'b1;
            default: cmd_known = 1'b0;
        endcase
    end

    // Hundreds digit by a ladder of constant compares.
    always_comb begin
        logic [9:0] base;
        volts_mod = (i_volts >= 10'd1000) ? (i_volts - 10'd1000) : i_volts;
        n_hund = 4'd0;
        base   = 10'd0;
        for (int k = 1; k < 10; k++) begin
            if (volts_mod >= 10'(k * 100)) begin
                n_hund = 4'(k);
                base   = 10'(k * 100);
            end
        end
        n_rem = 7'(volts_mod - base);
    end

    always_comb begin
        logic [6:0] base;
        tens = 4'd0;
        base = 7'd0;
        for (int k = 1; k < 10; k++) begin
            if (r_s1_rem >= 7'(k * 10)) begin
                tens = 4'(k);
                base = 7'(k * 10);
            end
        end
        ones = 4'(r_s1_rem - base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_advance) begin
            r_s1_valid <= i_push && cmd_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_s1_cmd  <= clns_pkg::t_cmd'(i_command);
            r_s1_byte <= i_byte_value;
            r_s1_rs   <= i_rs_select;
            r_s1_hund <= n_hund;
            r_s1_rem  <= n_rem;
        end
    end

    always_comb begin
        o_req = '0;
        unique case (r_s1_cmd)
            clns_pkg::CMD_INIT: begin
                o_req.power_wait = 1'b1;
                o_req.last_byte  = 2'd3;
                o_req.clear_en   = 1'b1;
                o_req.clear_byte = 2'd2;
                o_req.bytes[0]   = clns_pkg::LCD_FUNCTION_SET;
                o_req.bytes[1]   = clns_pkg::LCD_DISPLAY_ON;
                o_req.bytes[2]   = clns_pkg::LCD_CLS;
                o_req.bytes[3]   = clns_pkg::LCD_ENTRY_MODE;
            end
            clns_pkg::CMD_CLEAR: begin
                o_req.clear_en = 1'b1;
                o_req.bytes[0] = clns_pkg::LCD_CLS;
            end
            clns_pkg::CMD_GOTO: begin
                o_req.clear_en = 1'b1;
                o_req.bytes[0] = clns_pkg::LCD_SET_DDRAM + r_s1_byte;
            end
            clns_pkg::CMD_PUT: begin
                o_req.rs       = 1'b1;
                o_req.bytes[0] = r_s1_byte;
            end
            clns_pkg::CMD_VOLTS: begin
                o_req.rs        = 1'b1;
                o_req.last_byte = 2'd3;
                o_req.bytes[0]  = clns_pkg::ASCII_ZERO | {4'd0, r_s1_hund};
                o_req.bytes[1]  = clns_pkg::ASCII_POINT;
                o_req.bytes[2]  = clns_pkg::ASCII_ZERO | {4'd0, tens};
                o_req.bytes[3]  = clns_pkg::ASCII_ZERO | {4'd0, ones};
            end
            clns_pkg::CMD_RAW: begin
                o_req.rs       = r_s1_rs;
                o_req.bytes[0] = r_s1_byte;
            end
            default: o_req = '0;
        endcase
    end

endmodule

>>> rtl/clns_queue.sv
// Short request queue between the front and back ends.
// Depends on clns_pkg for the descriptor type.
module clns_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  clns_pkg::t_req  i_data,
    output logic            o_full,
    output logic            o_valid,
    output clns_pkg::t_req  o_data,
    input  logic            i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    clns_pkg::t_req   r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= wrap_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= wrap_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> rtl/clns_back.sv
// Back end: walks the queue head one bus step per cycle unless output stalls.
// Depends on clns_pkg; drives the result register seen at the top level.
module clns_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clns_pkg::t_cfg  i_cfg,
    input  logic            i_req_valid,
    input  clns_pkg::t_req  i_req,
    output logic            o_req_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_strobe_res,
    output logic            o_rs,
    output logic [3:0]      o_nibble,
    output logic [7:0]      o_pulse_us,
    output logic [17:0]     o_wait_us,
    output logic            o_last
);

    logic [2:0]        r_nib;
    logic              r_wait_done;
    logic              r_out_valid;
    clns_pkg::t_step   r_out;

    logic              out_ready;
    logic              advance;
    logic              is_wait;
    clns_pkg::t_step   step;

    assign out_ready = !r_out_valid || i_pop;
    assign advance   = i_req_valid && out_ready;
    assign is_wait   = i_req.power_wait && !r_wait_done;
    assign o_req_pop = advance && step.last;

    always_comb begin
        logic [7:0] cur_byte;
        logic       clear_here;
        cur_byte   = i_req.bytes[r_nib[2:1]];
        clear_here = i_req.clear_en && r_nib[0] && (r_nib[2:1] == i_req.clear_byte);
        step = '0;
        if (is_wait) begin
            step.wait_us = i_cfg.power_us;
        end else begin
            step.strobe   = 1'b1;
            step.rs       = i_req.rs;
            step.nibble   = r_nib[0] ? cur_byte[3:0] : cur_byte[7:4];
            step.pulse_us = i_cfg.pulse_us;
            step.wait_us  = {10'd0, i_cfg.gap_us} + (clear_here ? i_cfg.clear_us : 18'd0);
            step.last     = (r_nib == {i_req.last_byte, 1'b1});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nib       <= '0;
            r_wait_done <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                if (step.last) begin
                    r_nib       <= '0;
                    r_wait_done <= 1'b0;
                end else if (is_wait) begin
                    r_wait_done <= 1'b1;
                end else begin
                    r_nib <= r_nib + 3'd1;
                end
            end
            if (out_ready) begin
                r_out_valid <= advance;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_strobe_res = r_out.strobe;
    assign o_rs         = r_out.rs;
    assign o_nibble     = r_out.nibble;
    assign o_pulse_us   = r_out.pulse_us;
    assign o_wait_us    = r_out.wait_us;
    assign o_last       = r_out.last;

    a_pop_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop |-> i_req_valid)
        else $error("request popped from an empty queue");

    a_wait_step_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.strobe) |-> (r_out.pulse_us == 8'd0 && !r_out.last))
        else $error("wait-only step carries a pulse or ends a run");

    a_nibble_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid |-> (r_nib[2:1] <= i_req.last_byte))
        else $error("step counter ran past the last byte of the request");

endmodule

>>> rtl/char_lcd_nibble_sequencer_top.sv
// Top level of the character LCD nibble sequencer: timing registers and the front/queue/back chain.
// Depends on clns_pkg, clns_front, clns_queue and clns_back.

// A request pushed here comes out as a run of 4-bit bus steps, one step per clock cycle
// while pop is held: nine steps for initialise, eight for show volts and two for every other
// request; unknown commands are dropped in the front end. Once the queue is empty, the first
// step of a request passes the front-end register, a queue slot and the result register on
// its way to the result ports. The front end takes a new request every cycle unless its register
// holds one and the queue is full; the back end emits one step per cycle from the request at the
// head of the queue while its result register is empty or being popped. Timing registers are
// written through i_cfg_we, i_cfg_index and i_cfg_data by the user only while the block is idle,
// which the block does not enforce; millisecond settings are scaled to microseconds as written.
module char_lcd_nibble_sequencer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_byte_value,
    input  logic        i_rs_select,
    input  logic [9:0]  i_volts,
    output logic        empty,
    input  logic        pop,
    output logic        o_strobe_res,
    output logic        o_rs,
    output logic [3:0]  o_nibble,
    output logic [7:0]  o_pulse_us,
    output logic [17:0] o_wait_us,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Timing settings, held in the form that the back end consumes directly.
    clns_pkg::t_cfg r_cfg;
    logic [17:0]    cfg_data_us;

    logic           front_valid;
    clns_pkg::t_req front_req;
    logic           queue_full;
    logic           queue_valid;
    clns_pkg::t_req queue_req;
    logic           queue_pop;

    // A millisecond setting becomes microseconds through one small constant multiply.
    assign cfg_data_us = 18'({10'd0, i_cfg_data} * clns_pkg::US_PER_MS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_us <= clns_pkg::RESET_PULSE_US;
            r_cfg.gap_us   <= clns_pkg::RESET_GAP_US;
            r_cfg.clear_us <= clns_pkg::RESET_CLEAR_US;
            r_cfg.power_us <= clns_pkg::RESET_POWER_US;
        end else if (i_cfg_we) begin
            unique case (clns_pkg::t_reg_index'(i_cfg_index))
                clns_pkg::REG_ENABLE_PULSE: r_cfg.pulse_us <= i_cfg_data;
                clns_pkg::REG_NIBBLE_GAP:   r_cfg.gap_us   <= i_cfg_data;
                clns_pkg::REG_CLEAR_WAIT:   r_cfg.clear_us <= cfg_data_us;
                clns_pkg::REG_POWER_WAIT:   r_cfg.power_us <= cfg_data_us;
                default: ;
            endcase
        end
    end

    // The front end classifies each request and works out the voltage digits.
    clns_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_byte_value (i_byte_value),
        .i_rs_select  (i_rs_select),
        .i_volts      (i_volts),
        .o_req_valid  (front_valid),
        .o_req        (front_req),
        .i_req_full   (queue_full)
    );

    // The queue lets the front end keep accepting while the back end works through a long run.
    clns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_req),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_data  (queue_req),
        .i_pop   (queue_pop)
    );

    // The back end turns the head request into bus steps and holds the result word.
    clns_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (queue_valid),
        .i_req        (queue_req),
        .o_req_pop    (queue_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_strobe_res (o_strobe_res),
        .o_rs         (o_rs),
        .o_nibble     (o_nibble),
        .o_pulse_us   (o_pulse_us),
        .o_wait_us    (o_wait_us),
        .o_last       (o_last)
    );

endmodule
